// ----- rtl/core/lslot_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lslot_pkg
// Shared constants and types for the lowest-slot value table.
// ----------------------------------------------------------------------------
package lslot_pkg;

	localparam int SLOT_FIELD_W   = 10;
	localparam int VALUE_FIELD_W  = 32;
	localparam int DEF_SLOT_COUNT  = 1024;
	localparam int DEF_VALUE_WIDTH = 32;

	localparam logic MODE_WRITE = 1'b0;
	localparam logic MODE_FIND  = 1'b1;

	// one find result as it leaves the scan controller
	typedef struct packed {
		logic                    hit;
		logic [SLOT_FIELD_W-1:0] slot;
	} lslot_result_t;

endpackage

// ----- rtl/core/lslot_ram.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lslot_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module lslot_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ----- rtl/core/lslot_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lslot_ctrl
// Sequencer around the slot memory: clearing pass after reset, direct writes,
// and the in-order find scan with one memory read per cycle.
// ----------------------------------------------------------------------------
module lslot_ctrl
	import lslot_pkg::*;
#(
	parameter int SLOT_COUNT  = DEF_SLOT_COUNT,
	parameter int VALUE_WIDTH = DEF_VALUE_WIDTH,
	localparam int IDX_W = $clog2(SLOT_COUNT),
	localparam int MEM_W = VALUE_WIDTH + 1
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  logic                            mode,
	input  logic [SLOT_FIELD_W-1:0]         slot,
	input  logic signed [VALUE_FIELD_W-1:0] value,
	input  logic                            out_free,
	output logic                            res_valid,
	output lslot_result_t                   res,
	output logic                            ram_we,
	output logic [IDX_W-1:0]                ram_waddr,
	output logic [MEM_W-1:0]                ram_wdata,
	output logic                            ram_re,
	output logic [IDX_W-1:0]                ram_raddr,
	input  logic [MEM_W-1:0]                ram_rdata
);

	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SLOT_COUNT - 1);

	typedef enum logic [1:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_SCAN
	} state_t;

	state_t                 state_q;
	logic [IDX_W-1:0]       ptr_q;
	logic                   issue_q;
	logic [VALUE_WIDTH-1:0] key_q;
	logic                   pend_s1;
	logic [IDX_W-1:0]       addr_s1;

	logic                   accept;
	logic [31:0]            slot_ext;
	logic                   slot_in_range;
	logic [63:0]            value_ext;
	logic [VALUE_WIDTH-1:0] value_key;
	logic                   match;
	logic                   last_s1;
	logic                   done;
	logic [31:0]            addr_ext;

	assign slot_ext      = 32'(slot);
	assign slot_in_range = slot_ext < 32'(SLOT_COUNT);
	assign value_ext     = 64'($unsigned(value));
	assign value_key     = value_ext[VALUE_WIDTH-1:0];

	// a find needs the output register free, since nothing else can hold it
	assign in_ready = (state_q == ST_IDLE) && ((mode == MODE_WRITE) || out_free);
	assign accept   = in_valid && in_ready;

	assign match   = pend_s1 && ram_rdata[VALUE_WIDTH]
			&& (ram_rdata[VALUE_WIDTH-1:0] == key_q);
	assign last_s1 = pend_s1 && (addr_s1 == LAST_IDX);
	assign done    = (state_q == ST_SCAN) && (match || last_s1);
	assign addr_ext = 32'(addr_s1);

	assign res_valid = done;
	assign res.hit   = match;
	assign res.slot  = match ? addr_ext[SLOT_FIELD_W-1:0] : '0;

	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = ptr_q;
		ram_wdata = '0;
		if (state_q == ST_CLEAR) begin
			ram_we = 1'b1;
		end else if (accept && (mode == MODE_WRITE) && slot_in_range) begin
			ram_we    = 1'b1;
			ram_waddr = slot_ext[IDX_W-1:0];
			ram_wdata = {1'b1, value_key};
		end
	end

	assign ram_re    = (state_q == ST_SCAN) && issue_q;
	assign ram_raddr = ptr_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			ptr_q   <= '0;
			issue_q <= 1'b0;
			pend_s1 <= 1'b0;
			addr_s1 <= '0;
			key_q   <= '0;
		end else begin
			unique case (state_q)
				ST_CLEAR: begin
					if (ptr_q == LAST_IDX) begin
						state_q <= ST_IDLE;
						ptr_q   <= '0;
					end else begin
						ptr_q <= ptr_q + 1'b1;
					end
				end
				ST_IDLE: begin
					if (accept && (mode == MODE_FIND)) begin
						state_q <= ST_SCAN;
						ptr_q   <= '0;
						issue_q <= 1'b1;
						key_q   <= value_key;
					end
				end
				ST_SCAN: begin
					if (done) begin
						// drop the read still in flight
						state_q <= ST_IDLE;
						issue_q <= 1'b0;
						pend_s1 <= 1'b0;
					end else begin
						pend_s1 <= issue_q;
						addr_s1 <= ptr_q;
						if (issue_q) begin
							if (ptr_q == LAST_IDX) begin
								issue_q <= 1'b0;
							end else begin
								ptr_q <= ptr_q + 1'b1;
							end
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

// ----- rtl/core/lowest_slot_of_value_table.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lowest_slot_of_value_table
// Value table with a find for the lowest valid slot holding a given value.
// Operation: a write gives no word; a find scans the slots in order, one memory
//   read per cycle, and raises out_valid from the registered result word.
// Throughput: a write every cycle while idle; a find holds the input until its
//   scan ends, and a further find also waits while the output word is still held.
// Reset: after arst_n releases, a clearing pass over all slots zeroes
//   every slot's valid bit; no word is accepted until it ends.
// ----------------------------------------------------------------------------
module lowest_slot_of_value_table
	import lslot_pkg::*;
#(
	parameter int SLOT_COUNT  = DEF_SLOT_COUNT,
	parameter int VALUE_WIDTH = DEF_VALUE_WIDTH
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  logic                            mode,
	input  logic [SLOT_FIELD_W-1:0]         slot,
	input  logic signed [VALUE_FIELD_W-1:0] value,
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic                            hit,
	output logic [SLOT_FIELD_W-1:0]         lowest_slot
);

	localparam int IDX_W = $clog2(SLOT_COUNT);
	localparam int MEM_W = VALUE_WIDTH + 1;

	logic                    out_valid_q;
	logic                    hit_q;
	logic [SLOT_FIELD_W-1:0] lowest_slot_q;
	logic                    out_free;
	logic                    res_valid;
	lslot_result_t           res;
	logic                    ram_we;
	logic [IDX_W-1:0]        ram_waddr;
	logic [MEM_W-1:0]        ram_wdata;
	logic                    ram_re;
	logic [IDX_W-1:0]        ram_raddr;
	logic [MEM_W-1:0]        ram_rdata;

	assign out_free = !out_valid_q || out_ready;

	lslot_ctrl #(
		.SLOT_COUNT  (SLOT_COUNT),
		.VALUE_WIDTH (VALUE_WIDTH)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.mode      (mode),
		.slot      (slot),
		.value     (value),
		.out_free  (out_free),
		.res_valid (res_valid),
		.res       (res),
		.ram_we    (ram_we),
		.ram_waddr (ram_waddr),
		.ram_wdata (ram_wdata),
		.ram_re    (ram_re),
		.ram_raddr (ram_raddr),
		.ram_rdata (ram_rdata)
	);

	lslot_ram #(
		.WIDTH (MEM_W),
		.DEPTH (SLOT_COUNT)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_valid) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid) begin
			hit_q         <= res.hit;
			lowest_slot_q <= res.slot;
		end
	end

	assign out_valid   = out_valid_q;
	assign hit         = hit_q;
	assign lowest_slot = lowest_slot_q;

`ifndef SYNTHESIS
	a_res_into_free: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> out_free)
		else $error("find result produced while output word still held");

	a_find_blocks_input: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready && (mode == MODE_FIND)) |=> !in_ready)
		else $error("input accepted during a find scan");

	a_find_waits_output: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !out_ready && (mode == MODE_FIND)) |-> !in_ready)
		else $error("find accepted while output word is stalled");

	a_miss_slot_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && !res.hit) |-> (res.slot == '0))
		else $error("miss result with nonzero slot");
`endif

endmodule

// ----- dv/tb_lowest_slot_of_value_table.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_lowest_slot_of_value_table
// Self-checking bench for the lowest-slot value table. A short table of
// directed words walks extremes, rewrites and misses; random writes and finds
// follow under several sender and receiver idling patterns, including one
// long receiver hold-off. Every find result is compared field by field with its
// typed result where given, else with a behavioral table copy kept in the bench.
// ----------------------------------------------------------------------------
module tb_lowest_slot_of_value_table;
	import lslot_pkg::*;

	localparam int SLOTS       = DEF_SLOT_COUNT;
	localparam int LONG_HOLD   = 3000;
	localparam int CYCLE_LIMIT = 2_500_000;
	localparam int ROW_COUNT   = 24;

	typedef enum int {PH_FREE, PH_SEND_IDLE, PH_RECV_STALL, PH_BOTH, PH_PRESSURE, PH_DRAIN}
		phase_t;

	typedef struct packed {
		logic                     m;
		logic [SLOT_FIELD_W-1:0]  s;
		logic [VALUE_FIELD_W-1:0] v;
		logic                     known;
		logic                     hit;
		logic [SLOT_FIELD_W-1:0]  low;
	} probe_row_t;

	// result typed in only where it is plain from the table contents so far
	localparam probe_row_t PROBES [0:ROW_COUNT-1] = '{
		'{MODE_FIND,  10'd0,    32'h0000_0000, 1'b1, 1'b0, 10'd0},
		'{MODE_FIND,  10'd1023, 32'h8000_0000, 1'b1, 1'b0, 10'd0},
		'{MODE_WRITE, 10'd1023, 32'h7FFF_FFFF, 1'b0, 1'b0, 10'd0},
		'{MODE_FIND,  10'd0,    32'h7FFF_FFFF, 1'b1, 1'b1, 10'd1023},
		'{MODE_WRITE, 10'd0,    32'h8000_0000, 1'b0, 1'b0, 10'd0},
		'{MODE_FIND,  10'd0,    32'h8000_0000, 1'b1, 1'b1, 10'd0},
		'{MODE_WRITE, 10'd512,  32'h7FFF_FFFF, 1'b0, 1'b0, 10'd0},
		'{MODE_FIND,  10'd0,    32'h7FFF_FFFF, 1'b1, 1'b1, 10'd512},
		'{MODE_WRITE, 10'd0,    32'h7FFF_FFFF, 1'b0, 1'b0, 10'd0},
		'{MODE_FIND,  10'd0,    32'h7FFF_FFFF, 1'b1, 1'b1, 10'd0},
		'{MODE_FIND,  10'd0,    32'h8000_0000, 1'b1, 1'b0, 10'd0},
		'{MODE_WRITE, 10'd5,    32'hFFFF_FFFF, 1'b0, 1'b0, 10'd0},
		'{MODE_WRITE, 10'd3,    32'hFFFF_FFFF, 1'b0, 1'b0, 10'd0},
		'{MODE_FIND,  10'd1023, 32'hFFFF_FFFF, 1'b0, 1'b0, 10'd0},
		'{MODE_WRITE, 10'd3,    32'h0000_0000, 1'b0, 1'b0, 10'd0},
		'{MODE_FIND,  10'd0,    32'hFFFF_FFFF, 1'b0, 1'b0, 10'd0},
		'{MODE_FIND,  10'd0,    32'h0000_0000, 1'b0, 1'b0, 10'd0},
		'{MODE_WRITE, 10'd1023, 32'h0000_0000, 1'b0, 1'b0, 10'd0},
		'{MODE_FIND,  10'd0,    32'h0000_0000, 1'b0, 1'b0, 10'd0},
		'{MODE_WRITE, 10'd341,  32'h5555_5555, 1'b0, 1'b0, 10'd0},
		'{MODE_WRITE, 10'd682,  32'hAAAA_AAAA, 1'b0, 1'b0, 10'd0},
		'{MODE_FIND,  10'd341,  32'hAAAA_AAAA, 1'b0, 1'b0, 10'd0},
		'{MODE_FIND,  10'd682,  32'h5555_5555, 1'b0, 1'b0, 10'd0},
		'{MODE_FIND,  10'd0,    32'h0000_0001, 1'b1, 1'b0, 10'd0}
	};

	logic                            clk;
	logic                            arst_n;
	logic                            in_valid;
	logic                            in_ready;
	logic                            mode;
	logic [SLOT_FIELD_W-1:0]         slot;
	logic signed [VALUE_FIELD_W-1:0] value;
	logic                            out_valid;
	logic                            out_ready;
	logic                            hit;
	logic [SLOT_FIELD_W-1:0]         lowest_slot;

	// bench-side companions of the word on the input
	logic          row_known;
	lslot_result_t row_result;

	phase_t phase_id;

	bit                     slot_written [SLOTS];
	bit [VALUE_FIELD_W-1:0] stored_value [SLOTS];
	lslot_result_t          pending_finds [$];
	int                     error_count;
	int                     cycle_count;

	lowest_slot_of_value_table dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.mode       (mode),
		.slot       (slot),
		.value      (value),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.hit        (hit),
		.lowest_slot(lowest_slot)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic lslot_result_t lowest_match(input logic [VALUE_FIELD_W-1:0] key);
		lslot_result_t r;
		r = '0;
		// walk downward so the last hit seen is the lowest slot
		for (int k = SLOTS - 1; k >= 0; k--) begin
			if (slot_written[k] && stored_value[k] == key) begin
				r.hit  = 1'b1;
				r.slot = k[SLOT_FIELD_W-1:0];
			end
		end
		return r;
	endfunction

	function automatic int send_idle_pct(input phase_t ph);
		case (ph)
			PH_SEND_IDLE: return 58;
			PH_BOTH:      return 16;
			default:      return 0;
		endcase
	endfunction

	function automatic int recv_stall_pct(input phase_t ph);
		case (ph)
			PH_RECV_STALL: return 58;
			PH_BOTH:       return 16;
			default:       return 0;
		endcase
	endfunction

	// track accepted words in the table copy and check every find result
	always @(posedge clk) begin
		lslot_result_t want;
		if (arst_n && in_valid && in_ready) begin
			if (mode == MODE_WRITE) begin
				if (int'(slot) < SLOTS) begin
					slot_written[slot] = 1'b1;
					stored_value[slot] = value;
				end
			end else begin
				want = lowest_match(value);
				pending_finds.push_back(row_known ? row_result : want);
			end
		end
		if (arst_n && out_valid && out_ready) begin
			if (pending_finds.size() == 0) begin
				$display("%0t: unexpected word: hit=%0b lowest_slot=%0d",
					$time, hit, lowest_slot);
				error_count++;
			end else begin
				want = pending_finds.pop_front();
				if (hit !== want.hit) begin
					$display("%0t: hit mismatch: expected %0b, actual %0b",
						$time, want.hit, hit);
					error_count++;
				end
				if (lowest_slot !== want.slot) begin
					$display("%0t: lowest_slot mismatch: expected %0d, actual %0d",
						$time, want.slot, lowest_slot);
					error_count++;
				end
			end
		end
	end

	// receiver: random stalls per phase, one long hold-off on entering pressure
	initial begin
		int     hold_left;
		phase_t seen;
		hold_left = 0;
		seen      = PH_FREE;
		out_ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (phase_id == PH_PRESSURE && seen != PH_PRESSURE)
				hold_left = LONG_HOLD;
			seen = phase_id;
			if (hold_left > 0) begin
				hold_left--;
				out_ready <= 1'b0;
			end else begin
				out_ready <= ($urandom_range(0, 99) >= recv_stall_pct(phase_id));
			end
		end
	end

	initial begin
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("TEST FAILED");
		$finish;
	end

	// hold the word until accepted; returns in the step of acceptance
	task automatic offer_word(input logic m, input logic [SLOT_FIELD_W-1:0] s,
		input logic [VALUE_FIELD_W-1:0] v, input logic known, input lslot_result_t r,
		input int idle_pct);
		while ($urandom_range(0, 99) < idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid   <= 1'b1;
		mode       <= m;
		slot       <= s;
		value      <= v;
		row_known  <= known;
		row_result <= r;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
	endtask

	task automatic run_random(input phase_t ph, input int count);
		logic [VALUE_FIELD_W-1:0] pool [8];
		logic                     m;
		logic [SLOT_FIELD_W-1:0]  s;
		logic [VALUE_FIELD_W-1:0] v;
		phase_id <= ph;
		for (int i = 0; i < 8; i++)
			pool[i] = $urandom;
		pool[0] = 32'h8000_0000;
		pool[1] = 32'h7FFF_FFFF;
		repeat (count) begin
			// pressure leans on finds so the held result backs up the input
			m = ($urandom_range(0, 99) < (ph == PH_PRESSURE ? 80 : 40)) ? MODE_FIND
				: MODE_WRITE;
			if (m == MODE_WRITE)
				s = SLOT_FIELD_W'(($urandom_range(0, 99) < 70) ? $urandom_range(0, 31)
					: $urandom_range(0, SLOTS - 1));
			else
				s = SLOT_FIELD_W'($urandom_range(0, 1023));
			v = ($urandom_range(0, 99) < 78) ? pool[$urandom_range(0, 7)] : $urandom;
			offer_word(m, s, v, 1'b0, '0, send_idle_pct(ph));
		end
	endtask

	initial begin
		lslot_result_t r;
		error_count = 0;
		phase_id   <= PH_FREE;
		arst_n     <= 1'b0;
		in_valid   <= 1'b0;
		mode       <= MODE_WRITE;
		slot       <= '0;
		value      <= '0;
		row_known  <= 1'b0;
		row_result <= '0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		for (int i = 0; i < ROW_COUNT; i++) begin
			r.hit  = PROBES[i].hit;
			r.slot = PROBES[i].low;
			offer_word(PROBES[i].m, PROBES[i].s, PROBES[i].v, PROBES[i].known, r, 0);
		end

		run_random(PH_FREE, 140);
		run_random(PH_SEND_IDLE, 140);
		run_random(PH_RECV_STALL, 140);
		run_random(PH_PRESSURE, 20);
		run_random(PH_BOTH, 120);

		in_valid <= 1'b0;
		phase_id <= PH_DRAIN;
		while (pending_finds.size() != 0) @(posedge clk);
		repeat (SLOTS + 8) @(posedge clk);

		if (error_count == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule
